[hdl/wmm_pkg.sv]
package wmm_pkg;

	localparam int IDX_BITS   = 4;
	localparam int VALUE_BITS = 16;
	localparam int CFG_BITS   = 5;
	localparam int PROD_BITS  = 48;
	localparam int KIND_BITS  = 2;
	localparam int REG_BITS   = 2;
	localparam logic [CFG_BITS-1:0] DIM_RESET = 5'd16;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_WRITE_A = 2'd0,
		KIND_WRITE_B = 2'd1,
		KIND_READ    = 2'd2
	} kind_t;

	typedef enum logic [REG_BITS-1:0] {
		REG_A_ROWS     = 2'd0,
		REG_INNER_SIZE = 2'd1,
		REG_B_COLS     = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_AA,
		MUL_BB,
		MUL_CROSS,
		MUL_ODD
	} mul_sel_t;

	typedef struct packed {
		logic     capture;
		logic     write_a;
		logic     write_b;
		logic     fetch;
		mul_sel_t mul_sel;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic bad;
		logic pairs_left;
		logic odd;
	} dp_status_t;

endpackage

[hdl/wmm_if.sv]
interface wmm_item_if;
	logic                                   valid;
	logic                                   ready;
	logic [wmm_pkg::KIND_BITS-1:0]          kind;
	logic [wmm_pkg::IDX_BITS-1:0]           row;
	logic [wmm_pkg::IDX_BITS-1:0]           col;
	logic signed [wmm_pkg::VALUE_BITS-1:0]  value;

	modport source (output valid, kind, row, col, value, input ready);
	modport sink (input valid, kind, row, col, value, output ready);
endinterface

interface wmm_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [wmm_pkg::PROD_BITS-1:0]  product;
	logic                                  bad_index;

	modport source (output valid, product, bad_index, input ready);
	modport sink (input valid, product, bad_index, output ready);
endinterface

interface wmm_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [wmm_pkg::REG_BITS-1:0]  index;
	logic [wmm_pkg::CFG_BITS-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/wmm_ram.sv]
module wmm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

[hdl/wmm_dp.sv]
module wmm_dp #(
	parameter int MAX_DIM   = 16,
	parameter int ELEM_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [wmm_pkg::REG_BITS-1:0]          cfg_index,
	input  logic [wmm_pkg::CFG_BITS-1:0]          cfg_data,
	input  logic [wmm_pkg::IDX_BITS-1:0]          row,
	input  logic [wmm_pkg::IDX_BITS-1:0]          col,
	input  logic signed [wmm_pkg::VALUE_BITS-1:0] value,
	input  wmm_pkg::dp_cmd_t                      cmd,
	output wmm_pkg::dp_status_t                   st,
	output logic signed [wmm_pkg::PROD_BITS-1:0]  product,
	output logic                                  bad_index
);
	import wmm_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(MAX_DIM + 1);
	localparam int KW    = $clog2(MAX_DIM / 2 + 1);
	localparam int OW    = ELEM_BITS + 1;
	localparam int PW    = 2 * OW;

	function automatic logic [NW-1:0] clamp_dim(input logic [CFG_BITS-1:0] v);
		if (int'(v) > MAX_DIM) begin
			return NW'(MAX_DIM);
		end
		return NW'(v);
	endfunction

	logic [CFG_BITS-1:0] a_rows_q, inner_size_q, b_cols_q;
	logic [NW-1:0]       ar_c, n_c, bc_c;
	logic [IDX_BITS-1:0] r_q, c_q;
	logic                bad_q;
	logic [KW-1:0]       k_q;

	logic                         wr_ok;
	logic [AW-1:0]                waddr;
	logic signed [ELEM_BITS-1:0]  wr_elem;
	logic [AW-1:0]                a_raddr0, a_raddr1, b_raddr0, b_raddr1;
	logic [ELEM_BITS-1:0]         a_rd0, a_rd1, b_rd0, b_rd1;
	logic signed [ELEM_BITS-1:0]  a0, a1, b0, b1;

	logic signed [OW-1:0]         op_x, op_y;
	logic signed [PW-1:0]         prod_s1;
	logic                         prod_vld_s1, sub_s1;
	logic signed [PROD_BITS-1:0]  prod_w, acc_q;
	logic signed [PROD_BITS-1:0]  product_q;
	logic                         bad_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q     <= DIM_RESET;
			inner_size_q <= DIM_RESET;
			b_cols_q     <= DIM_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_A_ROWS:     a_rows_q     <= cfg_data;
				REG_INNER_SIZE: inner_size_q <= cfg_data;
				REG_B_COLS:     b_cols_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ar_c = clamp_dim(a_rows_q);
	assign n_c  = clamp_dim(inner_size_q);
	assign bc_c = clamp_dim(b_cols_q);

	assign st.bad        = (int'(row) >= int'(ar_c)) || (int'(col) >= int'(bc_c));
	assign st.pairs_left = int'(k_q) < int'(n_c >> 1);
	assign st.odd        = n_c[0];

	// store writes: rows or columns past the store are dropped
	assign wr_ok   = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
	assign waddr   = AW'(int'(row) * MAX_DIM + int'(col));
	assign wr_elem = ELEM_BITS'(value);

	// pair k reads columns 2k and 2k+1 of A's row, rows 2k and 2k+1 of B's column
	assign a_raddr0 = AW'(int'(r_q) * MAX_DIM + 2 * int'(k_q));
	assign a_raddr1 = AW'(int'(r_q) * MAX_DIM + 2 * int'(k_q) + 1);
	assign b_raddr0 = AW'(2 * int'(k_q) * MAX_DIM + int'(c_q));
	assign b_raddr1 = AW'((2 * int'(k_q) + 1) * MAX_DIM + int'(c_q));

	wmm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_a_store (
		.clk    (clk),
		.we     (cmd.write_a && wr_ok),
		.waddr  (waddr),
		.wdata  (wr_elem),
		.re     (cmd.fetch),
		.raddr0 (a_raddr0),
		.raddr1 (a_raddr1),
		.rdata0 (a_rd0),
		.rdata1 (a_rd1)
	);

	wmm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_b_store (
		.clk    (clk),
		.we     (cmd.write_b && wr_ok),
		.waddr  (waddr),
		.wdata  (wr_elem),
		.re     (cmd.fetch),
		.raddr0 (b_raddr0),
		.raddr1 (b_raddr1),
		.rdata0 (b_rd0),
		.rdata1 (b_rd1)
	);

	assign a0 = a_rd0;
	assign a1 = a_rd1;
	assign b0 = b_rd0;
	assign b1 = b_rd1;

	always_comb begin
		case (cmd.mul_sel)
			MUL_AA: begin
				op_x = OW'(a0);
				op_y = OW'(a1);
			end
			MUL_BB: begin
				op_x = OW'(b0);
				op_y = OW'(b1);
			end
			MUL_CROSS: begin
				op_x = OW'(a0) + OW'(b1);
				op_y = OW'(a1) + OW'(b0);
			end
			MUL_ODD: begin
				op_x = OW'(a0);
				op_y = OW'(b0);
			end
			default: begin
				op_x = '0;
				op_y = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
			sub_s1      <= 1'b0;
		end else begin
			prod_vld_s1 <= cmd.mul_sel != MUL_NONE;
			sub_s1      <= (cmd.mul_sel == MUL_AA) || (cmd.mul_sel == MUL_BB);
		end
	end

	// everything is modulo 2^48, so wide products just drop their top bits
	assign prod_w = PROD_BITS'(prod_s1);

	always_ff @(posedge clk) begin
		prod_s1 <= op_x * op_y;
		if (cmd.capture) begin
			r_q   <= row;
			c_q   <= col;
			bad_q <= st.bad;
			k_q   <= '0;
			acc_q <= '0;
		end else begin
			if (cmd.fetch) begin
				k_q <= k_q + KW'(1);
			end
			if (prod_vld_s1) begin
				acc_q <= sub_s1 ? acc_q - prod_w : acc_q + prod_w;
			end
		end
		if (cmd.load_out) begin
			product_q   <= bad_q ? '0 : acc_q;
			bad_index_q <= bad_q;
		end
	end

	assign product   = product_q;
	assign bad_index = bad_index_q;

endmodule

[hdl/wmm_ctrl.sv]
module wmm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic [wmm_pkg::KIND_BITS-1:0] req_kind,
	output logic                          req_ready,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	input  wmm_pkg::dp_status_t           st,
	output wmm_pkg::dp_cmd_t              cmd
);
	import wmm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_ODD,
		ST_FIN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept, slot_free, more;

	assign req_ready = state_q == ST_IDLE;
	assign accept    = req_valid && req_ready;
	assign slot_free = !out_valid_q || rsp_ready;
	assign more      = st.pairs_left || st.odd;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd = '{default: '0, mul_sel: MUL_NONE};
		if (accept) begin
			unique case (req_kind)
				KIND_WRITE_A: cmd.write_a = 1'b1;
				KIND_WRITE_B: cmd.write_b = 1'b1;
				KIND_READ:    cmd.capture = 1'b1;
				default: ;
			endcase
		end
		unique case (state_q)
			ST_START: cmd.fetch = more;
			ST_M0:    cmd.mul_sel = MUL_AA;
			ST_M1:    cmd.mul_sel = MUL_BB;
			ST_M2: begin
				cmd.mul_sel = MUL_CROSS;
				// prefetch the next pair, or the odd column, under the cross product
				cmd.fetch   = more;
			end
			ST_ODD:   cmd.mul_sel = MUL_ODD;
			ST_DONE:  cmd.load_out = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req_kind == KIND_READ) begin
						state_q <= st.bad ? ST_DONE : ST_START;
					end
				end
				ST_START: begin
					if (st.pairs_left) begin
						state_q <= ST_M0;
					end else if (st.odd) begin
						state_q <= ST_ODD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: begin
					if (st.pairs_left) begin
						state_q <= ST_M0;
					end else if (st.odd) begin
						state_q <= ST_ODD;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_ODD: state_q <= ST_FIN;
				// last product lands in the accumulator here
				ST_FIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hdl/winograd_matrix_multiply.sv]
// Winograd matrix product, one element per read item. Write items (kind 0 for A,
// kind 1 for B) store one element each. A read item (kind 2) returns C[row][col]
// of A*B, summed over the first n columns of A and rows of B, where n is
// inner_size capped at MAX_DIM; the three products of each pair share one
// multiplier, and each store is a RAM with two registered read ports that fetches
// a whole pair in a single read. A read outside a_rows by b_cols goes straight to
// the done state and returns zero with bad_index set. A finished read waits, and
// holds off new items, while an earlier result is still not taken. Elements of A
// or B that are read must have been written first. Write the size registers only
// while no read is in flight.
module winograd_matrix_multiply #(
	parameter int MAX_DIM   = 16,
	parameter int ELEM_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	wmm_item_if.sink     req,
	wmm_result_if.source rsp,
	wmm_cfg_if.sink      cfg
);
	import wmm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	assign cfg.ready = 1'b1;

	wmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.kind),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	wmm_dp #(.MAX_DIM(MAX_DIM), .ELEM_BITS(ELEM_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.row       (req.row),
		.col       (req.col),
		.value     (req.value),
		.cmd       (cmd),
		.st        (st),
		.product   (rsp.product),
		.bad_index (rsp.bad_index)
	);

endmodule

[hdl/wmm_chk.sv]
module wmm_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 req_valid,
	input logic                                 req_ready,
	input logic [wmm_pkg::KIND_BITS-1:0]        req_kind,
	input logic                                 rsp_valid,
	input logic                                 rsp_ready,
	input logic signed [wmm_pkg::PROD_BITS-1:0] rsp_product,
	input logic                                 rsp_bad_index
);
	import wmm_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_product) && $stable(rsp_bad_index))
		else $error("result changed while stalled");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_bad_index |-> rsp_product == '0)
		else $error("bad read returned a nonzero product");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_kind == KIND_READ |=> !req_ready)
		else $error("new item taken right after a read");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_kind != KIND_READ && !rsp_valid |=> !rsp_valid)
		else $error("result appeared for a non-read item");

endmodule

bind winograd_matrix_multiply wmm_chk u_wmm_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_kind      (req.kind),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_product   (rsp.product),
	.rsp_bad_index (rsp.bad_index)
);
